// ===== hw/rtl/pcl_pkg.sv =====
// Shared types and constants for the per-class LRU list block.
// No dependencies; imported by the slot table, the class table and the top level.
package pcl_pkg;

  localparam int ACTION_W     = 2;
  localparam int STATUS_W     = 2;
  localparam int SLOT_FIELD_W = 10;
  localparam int CLASS_W      = 6;
  localparam int ITEM_BYTES_W = 21;
  localparam int COUNT_W      = 11;
  localparam int BYTES_W      = 31;

  localparam logic [ACTION_W-1:0] ACT_LINK   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_UNLINK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MOVE   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_LINKED     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_LINKED = 2'd2;

  // Field write enables for one slot-table entry.
  typedef struct packed {
    logic linked;
    logic prev;
    logic next;
  } slot_wmask_t;

  localparam slot_wmask_t WMASK_ALL  = '{linked: 1'b1, prev: 1'b1, next: 1'b1};
  localparam slot_wmask_t WMASK_PREV = '{linked: 1'b0, prev: 1'b1, next: 1'b0};
  localparam slot_wmask_t WMASK_NEXT = '{linked: 1'b0, prev: 1'b0, next: 1'b1};

endpackage

// ===== hw/rtl/per_class_lru_list.sv =====
// Per-class LRU list: top level with request sequencer and result register.
// Depends on pcl_pkg, pcl_slot_mem and pcl_class_mem.

// One recency-ordered doubly linked list is kept per slab class over a table
// of NUM_SLOTS item slots. Each request beat links an item at the head of its
// class list, unlinks it, or moves it to the head, and one result beat returns
// a status and the class's head, tail, item count and byte total after the
// request. Right after reset the block runs a clearing pass over the slot
// table; in_stall stays high until it ends. An item then needs k slot-table
// writes, where k is 0 to 4, done one at a time since the slot table has a
// single write port: the slot and class tables are read as the request is
// accepted, ST_EVAL evaluates the request and writes the class table, then
// the link rewrites follow one per cycle in ST_WRITE before ST_FIN. A rejected
// request needs no writes, and a move from the middle of a list all four. The
// next request beat is taken in ST_FIN of the current one when the output is
// free, and a finished result waits in the output register without holding up
// the next request until a second result is ready.
module per_class_lru_list
  import pcl_pkg::*;
#(
  parameter int NUM_SLOTS   = 1024,
  parameter int NUM_CLASSES = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [ACTION_W-1:0]     action,
  input  logic [SLOT_FIELD_W-1:0] item_slot,
  input  logic [CLASS_W-1:0]      lru_class,
  input  logic [ITEM_BYTES_W-1:0] item_bytes,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STATUS_W-1:0]     status,
  output logic                    list_empty,
  output logic [SLOT_FIELD_W-1:0] head_slot,
  output logic [SLOT_FIELD_W-1:0] tail_slot,
  output logic [COUNT_W-1:0]      class_count,
  output logic [BYTES_W-1:0]      class_bytes
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SLOTS - 1);
  localparam int NUM_OPS = 4;

  // Write slots in the order they must reach the slot table.
  localparam logic [1:0] OP_NEXT_PREV = 2'd0;  // prev of old successor
  localparam logic [1:0] OP_PREV_NEXT = 2'd1;  // next of old predecessor
  localparam logic [1:0] OP_SELF      = 2'd2;  // the item's own entry
  localparam logic [1:0] OP_HEAD_PREV = 2'd3;  // prev of the old head

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic in_accept;
  logic out_free;

  // Request captured at accept.
  logic [ACTION_W-1:0]     req_action;
  logic [LW-1:0]           req_slot;
  logic                    req_slot_ok;
  logic                    req_class_ok;
  logic [CW-1:0]           req_class;
  logic [ITEM_BYTES_W-1:0] req_bytes;

  // Memory read data.
  logic          sl_linked;
  logic [LW-1:0] sl_prev, sl_next;
  logic [LW-1:0] cl_head, cl_tail;
  logic [COUNT_W-1:0] cl_count;
  logic [BYTES_W-1:0] cl_bytes;

  // Evaluation.
  logic               do_unlink, do_link;
  logic [LW-1:0]      head_mid, tail_mid;
  logic [LW-1:0]      head_new, tail_new;
  logic [COUNT_W-1:0] count_new;
  logic [BYTES_W-1:0] bytes_new;
  logic [BYTES_W-1:0] bytes_ext;
  logic [STATUS_W-1:0] status_new;

  // Pending slot-table writes.
  logic [NUM_OPS-1:0] pend, pend_next;
  logic [AW-1:0]      op_addr   [NUM_OPS];
  slot_wmask_t        op_mask   [NUM_OPS];
  logic               op_linked [NUM_OPS];
  logic [LW-1:0]      op_prev   [NUM_OPS];
  logic [LW-1:0]      op_next   [NUM_OPS];
  logic [1:0]         pick;
  logic [NUM_OPS-1:0] pick_bit;

  logic [AW-1:0] clr_idx;

  // Result waiting for the output register.
  logic [STATUS_W-1:0]     res_status;
  logic                    res_empty;
  logic [SLOT_FIELD_W-1:0] res_head, res_tail;
  logic [COUNT_W-1:0]      res_count;
  logic [BYTES_W-1:0]      res_bytes;

  // Slot-table write port.
  logic          sw_en;
  logic [AW-1:0] sw_addr;
  slot_wmask_t   sw_mask;
  logic          sw_linked;
  logic [LW-1:0] sw_prev, sw_next;

  logic cw_en;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = !((state == ST_IDLE) || ((state == ST_FIN) && out_free));
  assign in_accept = in_valid && !in_stall;

  pcl_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_slot_mem (
    .clk       (clk),
    .rd_en     (in_accept),
    .rd_addr   (AW'(item_slot)),
    .rd_linked (sl_linked),
    .rd_prev   (sl_prev),
    .rd_next   (sl_next),
    .wr_en     (sw_en),
    .wr_addr   (sw_addr),
    .wr_mask   (sw_mask),
    .wr_linked (sw_linked),
    .wr_prev   (sw_prev),
    .wr_next   (sw_next)
  );

  pcl_class_mem #(
    .NUM_SLOTS   (NUM_SLOTS),
    .NUM_CLASSES (NUM_CLASSES)
  ) u_class_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_accept),
    .rd_addr  (CW'(lru_class)),
    .rd_head  (cl_head),
    .rd_tail  (cl_tail),
    .rd_count (cl_count),
    .rd_bytes (cl_bytes),
    .wr_en    (cw_en),
    .wr_addr  (req_class),
    .wr_head  (head_new),
    .wr_tail  (tail_new),
    .wr_count (count_new),
    .wr_bytes (bytes_new)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_action   <= action;
      req_slot     <= LW'(item_slot);
      req_slot_ok  <= (32'(item_slot) < 32'(NUM_SLOTS));
      req_class_ok <= (32'(lru_class) < 32'(NUM_CLASSES));
      req_class    <= CW'(lru_class);
      req_bytes    <= item_bytes;
    end
  end

  // Evaluate the request from the read data. A link value at or above
  // NUM_SLOTS counts as null, so every null test below is against NULL_LINK.
  always_comb begin
    do_unlink = req_slot_ok && req_class_ok && sl_linked &&
                ((req_action == ACT_UNLINK) || (req_action == ACT_MOVE));
    do_link   = req_slot_ok && req_class_ok &&
                (((req_action == ACT_LINK) && !sl_linked) ||
                 ((req_action == ACT_MOVE) && sl_linked));

    // Class head and tail once the item is taken out of its list.
    head_mid = cl_head;
    tail_mid = cl_tail;
    if (do_unlink) begin
      if (cl_head == req_slot) begin
        head_mid = sl_next;
      end
      if (cl_tail == req_slot) begin
        tail_mid = sl_prev;
      end
    end

    head_new = head_mid;
    tail_new = tail_mid;
    if (do_link) begin
      head_new = req_slot;
      if (tail_mid >= NULL_LINK) begin
        tail_new = req_slot;
      end
    end

    // A move removes and adds the same count and size, which cancel.
    bytes_ext = BYTES_W'(req_bytes);
    count_new = cl_count;
    bytes_new = cl_bytes;
    if (do_unlink && !do_link) begin
      count_new = cl_count - COUNT_W'(1);
      bytes_new = cl_bytes - bytes_ext;
    end else if (do_link && !do_unlink) begin
      count_new = cl_count + COUNT_W'(1);
      bytes_new = cl_bytes + bytes_ext;
    end

    status_new = STAT_OK;
    if (!req_class_ok) begin
      status_new = STAT_NOT_LINKED;
    end else if ((req_action != ACT_LINK) && (req_action != ACT_UNLINK) &&
                 (req_action != ACT_MOVE)) begin
      status_new = STAT_OK;
    end else if (!req_slot_ok) begin
      status_new = STAT_NOT_LINKED;
    end else if (req_action == ACT_LINK) begin
      status_new = sl_linked ? STAT_LINKED : STAT_OK;
    end else begin
      status_new = sl_linked ? STAT_OK : STAT_NOT_LINKED;
    end
  end

  assign cw_en = (state == ST_EVAL) && (do_unlink || do_link);

  // Lowest pending write goes first.
  always_comb begin
    pick = 2'd0;
    for (int i = NUM_OPS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        pick = 2'(i);
      end
    end
    pick_bit = NUM_OPS'(1) << pick;
  end

  always_comb begin
    sw_en     = 1'b0;
    sw_addr   = op_addr[pick];
    sw_mask   = op_mask[pick];
    sw_linked = op_linked[pick];
    sw_prev   = op_prev[pick];
    sw_next   = op_next[pick];
    case (state)
      ST_CLEAR: begin
        sw_en     = 1'b1;
        sw_addr   = clr_idx;
        sw_mask   = WMASK_ALL;
        sw_linked = 1'b0;
        sw_prev   = NULL_LINK;
        sw_next   = NULL_LINK;
      end
      ST_WRITE: begin
        sw_en = 1'b1;
      end
      default: begin
        sw_en = 1'b0;
      end
    endcase
  end

  // Plan the slot-table writes in the order the lists must see them. When an
  // item is moved, its own entry is rewritten once with the linked values.
  always_ff @(posedge clk) begin
    if (state == ST_EVAL) begin
      op_addr[OP_NEXT_PREV]   <= AW'(sl_next);
      op_mask[OP_NEXT_PREV]   <= WMASK_PREV;
      op_linked[OP_NEXT_PREV] <= 1'b0;
      op_prev[OP_NEXT_PREV]   <= sl_prev;
      op_next[OP_NEXT_PREV]   <= NULL_LINK;

      op_addr[OP_PREV_NEXT]   <= AW'(sl_prev);
      op_mask[OP_PREV_NEXT]   <= WMASK_NEXT;
      op_linked[OP_PREV_NEXT] <= 1'b0;
      op_prev[OP_PREV_NEXT]   <= NULL_LINK;
      op_next[OP_PREV_NEXT]   <= sl_next;

      op_addr[OP_SELF]        <= AW'(req_slot);
      op_mask[OP_SELF]        <= WMASK_ALL;
      op_linked[OP_SELF]      <= do_link;
      op_prev[OP_SELF]        <= NULL_LINK;
      op_next[OP_SELF]        <= do_link ? head_mid : NULL_LINK;

      op_addr[OP_HEAD_PREV]   <= AW'(head_mid);
      op_mask[OP_HEAD_PREV]   <= WMASK_PREV;
      op_linked[OP_HEAD_PREV] <= 1'b0;
      op_prev[OP_HEAD_PREV]   <= req_slot;
      op_next[OP_HEAD_PREV]   <= NULL_LINK;

      res_status <= status_new;
      if (req_class_ok) begin
        res_empty <= (count_new == '0);
        res_head  <= (head_new < NULL_LINK) ? SLOT_FIELD_W'(head_new) : '0;
        res_tail  <= (tail_new < NULL_LINK) ? SLOT_FIELD_W'(tail_new) : '0;
        res_count <= count_new;
        res_bytes <= bytes_new;
      end else begin
        res_empty <= 1'b1;
        res_head  <= '0;
        res_tail  <= '0;
        res_count <= '0;
        res_bytes <= '0;
      end
    end
  end

  always_comb begin
    pend_next = pend;
    case (state)
      ST_EVAL: begin
        pend_next[OP_NEXT_PREV] = do_unlink && (sl_next < NULL_LINK);
        pend_next[OP_PREV_NEXT] = do_unlink && (sl_prev < NULL_LINK);
        pend_next[OP_SELF]      = do_unlink || do_link;
        pend_next[OP_HEAD_PREV] = do_link && (head_mid < NULL_LINK);
      end
      ST_WRITE: begin
        pend_next = pend & ~pick_bit;
      end
      default: begin
        pend_next = pend;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_next = (pend_next != '0) ? ST_WRITE : ST_FIN;
      end
      ST_WRITE: begin
        if (pend_next == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (in_accept) begin
          state_next = ST_EVAL;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      pend      <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      status      <= res_status;
      list_empty  <= res_empty;
      head_slot   <= res_head;
      tail_slot   <= res_tail;
      class_count <= res_count;
      class_bytes <= res_bytes;
    end
  end

  // A request beat is only taken once all writes of the previous one landed.
  a_accept_when_settled: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> ((state == ST_IDLE) || (state == ST_FIN)))
    else $error("request taken while slot writes are outstanding");

  a_accept_then_eval: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_EVAL))
    else $error("accepted request not evaluated in the next cycle");

  a_slot_write_window: assert property (@(posedge clk) disable iff (rst)
    sw_en |-> ((state == ST_CLEAR) || (state == ST_WRITE)))
    else $error("slot table written outside the clear pass or write phase");

  a_write_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (pend != '0))
    else $error("write phase entered with no pending write");

  a_result_after_fin: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_FIN) && out_free) |=> out_valid)
    else $error("finished request did not reach the output register");

endmodule

// ===== hw/rtl/pcl_slot_mem.sv =====
// Slot table: per-slot linked flag, prev link and next link in one memory.
// Depends on pcl_pkg for the field write-enable type.
module pcl_slot_mem
  import pcl_pkg::*;
#(
  parameter int NUM_SLOTS = 1024
) (
  input  logic                                clk,
  input  logic                                rd_en,
  input  logic [$clog2(NUM_SLOTS)-1:0]        rd_addr,
  output logic                                rd_linked,
  output logic [$clog2(NUM_SLOTS+1)-1:0]      rd_prev,
  output logic [$clog2(NUM_SLOTS+1)-1:0]      rd_next,
  input  logic                                wr_en,
  input  logic [$clog2(NUM_SLOTS)-1:0]        wr_addr,
  input  slot_wmask_t                         wr_mask,
  input  logic                                wr_linked,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]      wr_prev,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]      wr_next
);

  localparam int LW = $clog2(NUM_SLOTS + 1);

  typedef struct packed {
    logic          linked;
    logic [LW-1:0] prev;
    logic [LW-1:0] next;
  } slot_entry_t;

  slot_entry_t mem [NUM_SLOTS];

  // Each field has its own write enable, so a neighbor's link can be
  // rewritten without reading the rest of its entry.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (wr_mask.linked) begin
        mem[wr_addr].linked <= wr_linked;
      end
      if (wr_mask.prev) begin
        mem[wr_addr].prev <= wr_prev;
      end
      if (wr_mask.next) begin
        mem[wr_addr].next <= wr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_linked <= mem[rd_addr].linked;
      rd_prev   <= mem[rd_addr].prev;
      rd_next   <= mem[rd_addr].next;
    end
  end

endmodule

// ===== hw/rtl/pcl_class_mem.sv =====
// Class table: head, tail, item count and byte total for each class.
// Depends on pcl_pkg for field widths; entries never written read as empty.
module pcl_class_mem
  import pcl_pkg::*;
#(
  parameter int NUM_SLOTS   = 1024,
  parameter int NUM_CLASSES = 64
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  logic                                                  rd_en,
  input  logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] rd_addr,
  output logic [$clog2(NUM_SLOTS+1)-1:0]                        rd_head,
  output logic [$clog2(NUM_SLOTS+1)-1:0]                        rd_tail,
  output logic [COUNT_W-1:0]                                    rd_count,
  output logic [BYTES_W-1:0]                                    rd_bytes,
  input  logic                                                  wr_en,
  input  logic [((NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1)-1:0] wr_addr,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]                        wr_head,
  input  logic [$clog2(NUM_SLOTS+1)-1:0]                        wr_tail,
  input  logic [COUNT_W-1:0]                                    wr_count,
  input  logic [BYTES_W-1:0]                                    wr_bytes
);

  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);

  typedef struct packed {
    logic [LW-1:0]      head;
    logic [LW-1:0]      tail;
    logic [COUNT_W-1:0] count;
    logic [BYTES_W-1:0] bytes;
  } class_entry_t;

  class_entry_t           mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] written;
  class_entry_t           rd_word;
  logic                   rd_written;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= '{head: wr_head, tail: wr_tail, count: wr_count, bytes: wr_bytes};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[rd_addr];
      end
    end
  end

  // An entry not written since reset is an empty list.
  assign rd_head  = rd_written ? rd_word.head  : NULL_LINK;
  assign rd_tail  = rd_written ? rd_word.tail  : NULL_LINK;
  assign rd_count = rd_written ? rd_word.count : '0;
  assign rd_bytes = rd_written ? rd_word.bytes : '0;

endmodule
